// ----- sv/ddsp_pkg.sv -----
package ddsp_pkg;

    // operation codes
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_EDGE  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam int VW = 6;     // vertex index width
    localparam int WW = 17;    // stored weight width
    localparam int DW = 23;    // distance width
    localparam logic [WW-1:0] NO_EDGE = 17'd100000;
    localparam logic [DW-1:0] DIST_MAX = {DW{1'b1}};

endpackage

// ----- sv/ddsp_ram.sv -----
module ddsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/dense_dijkstra_shortest_path.sv -----
// Clear: one matrix entry per cycle (weight memory write port).
// Edge: two writes. Query: a minimum scan and a relaxation pass over all N
// vertices for each settled vertex, through the one read port of the weight and
// distance memories, then a trace back from the end vertex and the path words out.
// One item at a time. Reset (rst_n, asynchronous, low) starts a clearing pass
// over the weight memory; no input word is taken until it ends.
module dense_dijkstra_shortest_path
    import ddsp_pkg::*;
#(
    parameter int VERTEX_COUNT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[1:0], edge_from[7:2], edge_to[13:8], edge_weight[29:14],
    // start_vertex[35:30], end_vertex[41:36], zero fill to 48
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // path_vertex[5:0], zero fill to 8
    output logic [7:0]  m_tdata,
    output logic        m_tlast     // last_of_path
);

    localparam logic [VW:0] NV = VW'(0) + (VW+1)'(VERTEX_COUNT);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_EDGE2, S_INIT, S_SCAN, S_SCAN_END, S_RELAX,
        S_RELAX_END, S_TRACE, S_TRACE_W, S_OUT
    } st_t;

    st_t              st_reg;
    logic [11:0]      cnt_reg;        // clear address / generic counter
    logic [VW:0]      idx_reg;        // scan index (one spare bit)
    logic             rv_reg;         // read issued, its data now on the read port
    logic [VW-1:0]    ridx_reg;       // index of that read
    logic [VW-1:0]    a_reg, b_reg, s_reg, e_reg, pick_reg, cur_reg;
    logic [15:0]      w_reg;
    logic [DW-1:0]    best_reg;
    logic             found_reg;
    logic [63:0]      vis_reg;
    logic [VW:0]      depth_reg, k_reg;
    logic             mv_reg, ml_reg;
    logic [VW-1:0]    mv_data_reg;

    // memories
    logic             w_we, d_we, p_we, st_we;
    logic [11:0]      w_wa, w_ra;
    logic [WW-1:0]    w_wd, w_rd;
    logic [VW-1:0]    d_wa, d_ra, p_wa, p_ra, st_wa, st_ra;
    logic [DW-1:0]    d_wd, d_rd;
    logic [VW-1:0]    p_wd, p_rd, st_wd, st_rd;

    ddsp_ram #(.WIDTH(WW), .DEPTH(4096)) u_w (.clk, .we(w_we), .waddr(w_wa),
        .wdata(w_wd), .raddr(w_ra), .rdata(w_rd));
    ddsp_ram #(.WIDTH(DW), .DEPTH(64)) u_d (.clk, .we(d_we), .waddr(d_wa),
        .wdata(d_wd), .raddr(d_ra), .rdata(d_rd));
    ddsp_ram #(.WIDTH(VW), .DEPTH(64)) u_p (.clk, .we(p_we), .waddr(p_wa),
        .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
    ddsp_ram #(.WIDTH(VW), .DEPTH(64)) u_s (.clk, .we(st_we), .waddr(st_wa),
        .wdata(st_wd), .raddr(st_ra), .rdata(st_rd));

    logic [1:0]  in_op;
    logic        in_acc;
    logic [VW:0] last_idx;
    logic [DW:0] cand;
    logic        rvis;
    logic        scan_take;

    assign in_op    = s_tdata[1:0];
    assign s_tready = (st_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = mv_reg;
    assign m_tdata  = {2'b00, mv_data_reg};
    assign m_tlast  = ml_reg;
    assign last_idx = NV - 1'b1;
    assign rvis     = vis_reg[ridx_reg];
    // sum of current best and the weight just read; diagonal stores 0
    assign cand     = {1'b0, best_reg} + (DW+1)'(w_rd);
    // distance just read is a new minimum among unvisited vertices
    assign scan_take = rv_reg && !rvis
                       && (d_rd < best_reg || (!found_reg && d_rd != DIST_MAX));

    // memory port control
    always_comb
    begin
        w_we = 1'b0; w_wa = cnt_reg; w_wd = NO_EDGE;
        w_ra = {pick_reg, idx_reg[VW-1:0]};
        d_we = 1'b0; d_wa = idx_reg[VW-1:0]; d_wd = DIST_MAX;
        d_ra = idx_reg[VW-1:0];
        p_we = 1'b0; p_wa = ridx_reg; p_wd = pick_reg;
        p_ra = cur_reg;
        st_we = 1'b0; st_wa = depth_reg[VW-1:0]; st_wd = cur_reg;
        st_ra = VW'(depth_reg - 1'b1 - k_reg);
        unique case (st_reg)
            S_CLR:
            begin
                w_we = 1'b1;
                w_wd = (cnt_reg[11:6] == cnt_reg[5:0]) ? '0 : NO_EDGE;
            end
            S_IDLE:
            begin
                if (in_acc && in_op == OP_CLEAR)
                begin
                    w_we = 1'b1; w_wa = '0; w_wd = '0;
                end
                else if (in_acc && in_op == OP_EDGE && s_tdata[29:14] != '0
                         && (VW+1)'(s_tdata[7:2]) < NV && (VW+1)'(s_tdata[13:8]) < NV
                         && s_tdata[7:2] != s_tdata[13:8])
                begin
                    w_we = 1'b1; w_wa = {s_tdata[7:2], s_tdata[13:8]};
                    w_wd = {1'b0, s_tdata[29:14]};
                end
            end
            S_EDGE2:
            begin
                w_we = 1'b1; w_wa = {b_reg, a_reg}; w_wd = {1'b0, w_reg};
            end
            S_INIT:
            begin
                d_we = 1'b1;
                d_wd = (idx_reg[VW-1:0] == s_reg) ? '0 : DIST_MAX;
            end
            S_RELAX, S_RELAX_END:
            begin
                d_ra = idx_reg[VW-1:0];
                if (rv_reg && !rvis && ridx_reg != pick_reg && cand < {1'b0, d_rd})
                begin
                    d_we = 1'b1; d_wa = ridx_reg; d_wd = cand[DW-1:0];
                    p_we = 1'b1;
                end
            end
            S_TRACE:
            begin
                st_we = 1'b1;
            end
            // hold the issued stack address while its data waits
            S_OUT:
            begin
                st_ra = rv_reg ? VW'(depth_reg - k_reg) : VW'(depth_reg - 1'b1 - k_reg);
            end
            default:
            begin
            end
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_CLR;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            rv_reg    <= 1'b0;
            mv_reg    <= 1'b0;
            vis_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            rv_reg   <= 1'b0;
            ridx_reg <= idx_reg[VW-1:0];
            if (mv_reg && m_tready)
            begin
                mv_reg <= 1'b0;
            end
            unique case (st_reg)
                S_CLR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 12'hFFF)
                    begin
                        st_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    a_reg <= s_tdata[7:2];
                    b_reg <= s_tdata[13:8];
                    w_reg <= s_tdata[29:14];
                    s_reg <= s_tdata[35:30];
                    e_reg <= s_tdata[41:36];
                    idx_reg <= '0;
                    if (in_acc)
                    begin
                        unique case (in_op)
                            OP_CLEAR:
                            begin
                                cnt_reg <= 12'd1;
                                st_reg  <= S_CLR;
                            end
                            OP_EDGE:
                            begin
                                if (w_we)
                                begin
                                    st_reg <= S_EDGE2;
                                end
                            end
                            OP_QUERY:
                            begin
                                if ((VW+1)'(s_tdata[35:30]) < NV
                                    && (VW+1)'(s_tdata[41:36]) < NV)
                                begin
                                    st_reg  <= S_INIT;
                                    vis_reg <= '0;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_EDGE2:
                begin
                    st_reg <= S_IDLE;
                end
                S_INIT:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == last_idx)
                    begin
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        best_reg  <= DIST_MAX;
                        st_reg    <= S_SCAN;
                    end
                end
                // minimum search: read one distance per cycle
                S_SCAN, S_SCAN_END:
                begin
                    if (scan_take)
                    begin
                        best_reg  <= d_rd;
                        pick_reg  <= ridx_reg;
                        found_reg <= 1'b1;
                    end
                    if (st_reg == S_SCAN)
                    begin
                        rv_reg  <= 1'b1;
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg == last_idx)
                        begin
                            st_reg <= S_SCAN_END;
                        end
                    end
                    else
                    begin
                        idx_reg <= '0;
                        if (found_reg || (rv_reg && !rvis && d_rd != DIST_MAX))
                        begin
                            st_reg <= S_RELAX;
                            vis_reg[scan_take ? ridx_reg : pick_reg] <= 1'b1;
                        end
                        else
                        begin
                            st_reg    <= S_TRACE;
                            cur_reg   <= e_reg;
                            depth_reg <= '0;
                        end
                    end
                end
                // relaxation: weight and distance read together
                S_RELAX, S_RELAX_END:
                begin
                    if (st_reg == S_RELAX)
                    begin
                        rv_reg  <= 1'b1;
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg == last_idx)
                        begin
                            st_reg <= S_RELAX_END;
                        end
                    end
                    else
                    begin
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        best_reg  <= DIST_MAX;
                        st_reg    <= S_SCAN;
                    end
                end
                // walk predecessors back from the end vertex
                S_TRACE:
                begin
                    depth_reg <= depth_reg + 1'b1;
                    if (cur_reg == s_reg || depth_reg == last_idx)
                    begin
                        k_reg  <= '0;
                        st_reg <= S_OUT;
                    end
                    else
                    begin
                        st_reg <= S_TRACE_W;
                    end
                end
                S_TRACE_W:
                begin
                    cur_reg <= p_rd;
                    st_reg  <= S_TRACE;
                end
                // stack read issued at k, data used when the output is free
                S_OUT:
                begin
                    if (!mv_reg || m_tready)
                    begin
                        if (rv_reg)
                        begin
                            mv_reg      <= 1'b1;
                            mv_data_reg <= st_rd;
                            ml_reg      <= (k_reg == depth_reg);
                            if (k_reg == depth_reg)
                            begin
                                st_reg <= S_IDLE;
                            end
                        end
                        else
                        begin
                            rv_reg <= 1'b1;
                            k_reg  <= k_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        rv_reg <= rv_reg;
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

    ap_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != S_IDLE) |-> !s_tready) else $error("input taken while busy");
    ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output word dropped");
    ap_vis_onehot_step: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_RELAX_END) |=> $stable(vis_reg)) else $error("visited changed");

endmodule
